@@ rtl/pcsg_pkg.sv @@
// Shared types, constants and helper functions of the diagonal Peano curve
// segment generator. No dependencies; used by pcsg_cell and the top level.
package pcsg_pkg;

  // Default parameter values
  localparam int DEF_MAX_DEPTH   = 8;
  localparam int DEF_COORD_WIDTH = 12;

  // Register fields and configuration port
  localparam int DEPTH_W   = 4;
  localparam int STEP_W    = 11;
  localparam int START_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd3;

  // Base-9 digit
  localparam int               DIGIT_W   = 4;
  localparam logic [DIGIT_W-1:0] DIGIT_TOP = 4'd8;

  // Heading
  localparam int               HEAD_W     = 10;
  localparam logic [HEAD_W-1:0] HEAD_START = 10'd1000;

  // Turn table, bit i set where entry i turns by +1 (others turn by -1)
  localparam logic [7:0] TURN_POS = 8'b1000_1110;

  // Move direction codes (heading mod 4)
  localparam logic [1:0] DIR_PP = 2'd0;  // +x +y
  localparam logic [1:0] DIR_PM = 2'd1;  // +x -y
  localparam logic [1:0] DIR_MM = 2'd2;  // -x -y
  localparam logic [1:0] DIR_MP = 2'd3;  // -x +y

  // Color table, {red, green, blue}
  localparam int COLOR_N = 9;
  localparam logic [23:0] COLOR_TAB [COLOR_N] = '{
    24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
    24'hFF8000, 24'h00FF80, 24'h80FF00
  };

  // Per-cell control from the top level
  typedef struct packed {
    logic step_en;
    logic restart;
    logic in_range;
  } pcsg_ctrl_t;

  // Link between neighboring cells: carry over current digits and
  // all-eight check over next digits
  typedef struct packed {
    logic carry;
    logic last;
  } pcsg_link_t;

  // Per-cell report back to the top level
  typedef struct packed {
    logic sel;
    logic turn_pos;
  } pcsg_rpt_t;

  // Heading mod 9: 64 is 1 mod 9, so fold the high bits onto the low six,
  // then reduce the small sum with a reciprocal multiply
  function automatic logic [3:0] mod9(input logic [HEAD_W-1:0] h);
    logic [6:0]  s;
    logic [13:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    s = 7'(h[9:6]) + 7'(h[5:0]);
    p = 14'(s) * 14'd57;
    q = p[12:9];
    r = s - 7'(q) * 7'd9;
    return r[3:0];
  endfunction

  // Color lookup with unused codes reading black
  function automatic logic [23:0] color_of(input logic [3:0] idx);
    logic [23:0] c;
    c = 24'h000000;
    if (idx < 4'(COLOR_N)) begin
      c = COLOR_TAB[idx];
    end
    return c;
  endfunction

endpackage

@@ rtl/peano_curve_segment_generator.sv @@
// Diagonal Peano curve segment generator, top level.
// Throughput: one segment per cycle while in_stall is low; the digit chain,
// heading step and point move are combinational. A two-entry output buffer, the
// output register and a skid entry for stalls, keeps input open.
// Reset (synchronous, rst_n low): registers but the payload to defaults, curve restarts.
// Depends on pcsg_pkg and pcsg_cell.
module peano_curve_segment_generator #(
  parameter int MAX_DEPTH   = pcsg_pkg::DEF_MAX_DEPTH,
  parameter int COORD_WIDTH = pcsg_pkg::DEF_COORD_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration port
  input  logic                           cfg_wr_en,
  input  logic [pcsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcsg_pkg::CFG_DAT_W-1:0] cfg_wdata,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_advance,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COORD_WIDTH-1:0]         out_from_x,
  output logic [COORD_WIDTH-1:0]         out_from_y,
  output logic [COORD_WIDTH-1:0]         out_to_x,
  output logic [COORD_WIDTH-1:0]         out_to_y,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           out_last
);
  import pcsg_pkg::*;

  localparam int RES_W = 4 * COORD_WIDTH + 25;
  localparam logic [DEPTH_W-1:0] MAX_D = DEPTH_W'(MAX_DEPTH);

  // Configuration registers
  logic [DEPTH_W-1:0] depth_r;
  logic [STEP_W-1:0]  step_r;
  logic [START_W-1:0] start_x_r;
  logic [START_W-1:0] start_y_r;

  // Curve state
  logic [COORD_WIDTH-1:0] cur_x_r, cur_y_r;
  logic [HEAD_W-1:0]      heading_r, heading_nxt;
  logic                   started_r;

  // Output buffer
  logic             out_v_r, skid_v_r;
  logic [RES_W-1:0] out_r, skid_r, res_nxt;

  // Chain signals
  pcsg_ctrl_t             ctrl   [MAX_DEPTH];
  pcsg_link_t             link   [MAX_DEPTH+1];
  pcsg_rpt_t              rpt    [MAX_DEPTH];
  logic [MAX_DEPTH-1:0]   sel_vec;
  logic [MAX_DEPTH-1:0]   up_vec;

  logic [DEPTH_W-1:0]     depth_use;
  logic                   accept, gen, pop, restart, turn_up, is_last;
  logic [COORD_WIDTH-1:0] step_ext, sx_ext, sy_ext;
  logic [COORD_WIDTH-1:0] from_x, from_y, to_x, to_y;
  logic [27:0]            step_wide, sx_wide, sy_wide;
  logic [23:0]            rgb;

  // Handshake
  assign in_stall = skid_v_r;
  assign accept   = in_valid & ~skid_v_r;
  assign gen      = accept & in_advance;
  assign pop      = out_v_r & ~out_stall;

  // Clamp depth to 1..MAX_DEPTH
  always_comb begin
    priority if (depth_r == '0) begin
      depth_use = DEPTH_W'(1);
    end else if (depth_r > MAX_D) begin
      depth_use = MAX_D;
    end else begin
      depth_use = depth_r;
    end
  end

  // Digit chain
  assign link[0].carry = 1'b1;
  assign link[0].last  = 1'b1;
  assign restart       = ~started_r | link[MAX_DEPTH].carry;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    assign ctrl[i].step_en  = gen;
    assign ctrl[i].restart  = restart;
    assign ctrl[i].in_range = (DEPTH_W'(i) < depth_use);
    assign sel_vec[i]       = rpt[i].sel;
    assign up_vec[i]        = rpt[i].sel & rpt[i].turn_pos;

    pcsg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[i]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .rpt      (rpt[i])
    );
  end

  assign turn_up = |up_vec;
  assign is_last = link[MAX_DEPTH].last;

  // Heading: reload on restart, otherwise turn by one
  always_comb begin
    priority if (restart) begin
      heading_nxt = HEAD_START;
    end else if (turn_up) begin
      heading_nxt = heading_r + 10'd1;
    end else begin
      heading_nxt = heading_r - 10'd1;
    end
  end

  // Resize register fields to the coordinate width
  assign step_wide = {17'b0, step_r};
  assign sx_wide   = {16'b0, start_x_r};
  assign sy_wide   = {16'b0, start_y_r};
  assign step_ext  = step_wide[COORD_WIDTH-1:0];
  assign sx_ext    = sx_wide[COORD_WIDTH-1:0];
  assign sy_ext    = sy_wide[COORD_WIDTH-1:0];

  // Move one diagonal step from the current point
  assign from_x = restart ? sx_ext : cur_x_r;
  assign from_y = restart ? sy_ext : cur_y_r;

  always_comb begin
    unique case (heading_nxt[1:0])
      DIR_PP: begin
        to_x = from_x + step_ext;
        to_y = from_y + step_ext;
      end
      DIR_PM: begin
        to_x = from_x + step_ext;
        to_y = from_y - step_ext;
      end
      DIR_MM: begin
        to_x = from_x - step_ext;
        to_y = from_y - step_ext;
      end
      DIR_MP: begin
        to_x = from_x - step_ext;
        to_y = from_y + step_ext;
      end
      default: begin
        to_x = from_x;
        to_y = from_y;
      end
    endcase
  end

  assign rgb     = color_of(mod9(heading_nxt));
  assign res_nxt = {from_x, from_y, to_x, to_y, rgb, is_last};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= DEPTH_W'(1);
      step_r    <= STEP_W'(1);
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEPTH:   depth_r   <= cfg_wdata[DEPTH_W-1:0];
        REG_STEP:    step_r    <= cfg_wdata[STEP_W-1:0];
        REG_START_X: start_x_r <= cfg_wdata[START_W-1:0];
        REG_START_Y: start_y_r <= cfg_wdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance curve state on each segment beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      heading_r <= HEAD_START;
      started_r <= 1'b0;
    end else if (gen) begin
      cur_x_r   <= to_x;
      cur_y_r   <= to_y;
      heading_r <= heading_nxt;
      started_r <= ~is_last;
    end
  end

  // Output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= gen;
      end
    end else if (gen) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload moves, no reset
  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      out_r <= skid_v_r ? skid_r : res_nxt;
    end else if (gen) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid  = out_v_r;
  assign out_from_x = out_r[RES_W-1 -: COORD_WIDTH];
  assign out_from_y = out_r[RES_W-1-COORD_WIDTH -: COORD_WIDTH];
  assign out_to_x   = out_r[RES_W-1-2*COORD_WIDTH -: COORD_WIDTH];
  assign out_to_y   = out_r[RES_W-1-3*COORD_WIDTH -: COORD_WIDTH];
  assign out_red    = out_r[24:17];
  assign out_green  = out_r[16:9];
  assign out_blue   = out_r[8:1];
  assign out_last   = out_r[0];

  // At most one digit takes the increment
  a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_vec))
    else $error("more than one digit cell selected");

  // Skid entry is only used behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid with empty output register");

  // A curve restart reloads the heading
  a_restart_head: assert property (@(posedge clk) disable iff (!rst_n)
    (gen && restart) |=> (heading_r == HEAD_START))
    else $error("heading not reloaded on curve restart");

  // The final segment rearms the curve start
  a_last_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (gen && is_last) |=> !started_r)
    else $error("curve not rearmed after last segment");

endmodule

@@ rtl/pcsg_cell.sv @@
// One base-9 digit cell of the segment counter chain.
// Depends on pcsg_pkg for the link, control and report types.
module pcsg_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  pcsg_pkg::pcsg_ctrl_t ctrl,
  input  pcsg_pkg::pcsg_link_t link_in,
  output pcsg_pkg::pcsg_link_t link_out,
  output pcsg_pkg::pcsg_rpt_t  rpt
);
  import pcsg_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic               is_eight;
  logic               sel;

  // This active cell takes the increment when it is not eight and all lower digits are eight
  assign is_eight = (digit_r == DIGIT_TOP);
  assign sel      = link_in.carry & ctrl.in_range & ~is_eight;

  // Next digit: clear on restart, bump when selected, clear below the pick
  always_comb begin
    priority if (ctrl.restart) begin
      digit_nxt = '0;
    end else if (sel) begin
      digit_nxt = digit_r + 4'd1;
    end else if (link_in.carry) begin
      digit_nxt = '0;
    end else begin
      digit_nxt = digit_r;
    end
  end

  // Pass carry and end-of-curve check to the next cell
  assign link_out.carry = link_in.carry & (~ctrl.in_range | is_eight);
  assign link_out.last  = link_in.last & (~ctrl.in_range | (digit_nxt == DIGIT_TOP));

  assign rpt.sel      = sel;
  assign rpt.turn_pos = TURN_POS[digit_r[2:0]];

  // Hold the digit, advance on each segment beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
    end else if (ctrl.step_en) begin
      digit_r <= digit_nxt;
    end
  end

endmodule
